FILE: hw/rtl/serial_message_deframer_core_assert.svh
// ============================================================================
// Assertion macros for the serial message deframer
// Concurrent checks on aclk, disabled while aresetn is low.
// ============================================================================
`ifndef SERIAL_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define SERIAL_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer check failed");
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define SMD_ASSERT_SAME(label, ante, cons)
`define SMD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/smd_pkg.sv
// ============================================================================
// Serial message deframer package
// Types and fixed constants used by the deframer core.
// ============================================================================
package smd_pkg;

    localparam logic [7:0] SYNC_RESET = 8'h01;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SYNC = 3'd1,
        PH_ADDR = 3'd2,
        PH_LEN  = 3'd3,
        PH_CMD  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EM_ACCEPT = 2'd0,
        EM_READ   = 2'd1,
        EM_LOAD   = 2'd2
    } emit_state_t;

    typedef struct packed {
        logic       last;
        logic       has_payload;
        logic [7:0] payload_byte;
        logic [4:0] byte_index;
        logic [5:0] msg_length;
        logic [7:0] msg_command;
        logic [7:0] msg_address;
    } result_t;

endpackage

FILE: hw/rtl/smd_payload_ram.sv
// ============================================================================
// Payload store
// Single write port, single read port, registered read data.
// ============================================================================
module smd_payload_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/serial_message_deframer_core.sv
// ============================================================================
// Serial message deframer core
// Parses sync, address, length, command, payload and checksum bytes and
// emits the completed message one payload byte per result.
// ============================================================================
// Each byte request is taken while no message is being emitted.
// After the checksum byte, each payload result takes a store read (EM_READ)
// then an output register load (EM_LOAD); a header-only result goes straight
// to EM_LOAD. A load waits while an unaccepted result holds the output.
// Reset: synchronous, active-low aresetn; parser hunts for sync, sync byte
// returns to 0x01, output channel empties. Store contents are not cleared.
module serial_message_deframer_core
    import smd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // sync_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // rx_byte
    input  logic [0:0]  s_tuser,       // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // msg_address, msg_command, msg_length,
                                       // byte_index, payload_byte, zero pad
    output logic [0:0]  m_tuser,       // has_payload
    output logic        m_tlast        // last
);

`include "serial_message_deframer_core_assert.svh"

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W = LEN_W + 1;
    localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

    logic [7:0]  sync_reg;
    phase_t      phase_reg,  phase_next;
    logic [7:0]  addr_reg,   addr_next;
    logic [7:0]  cmd_reg,    cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    emit_state_t em_reg,     em_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic        zero_reg,   zero_next;
    result_t     out_reg,    out_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic        s_accept;
    logic        out_load;
    logic        ram_we;
    logic        ram_re;
    logic [7:0]  ram_rd_data;
    logic        idx_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (em_reg == EM_ACCEPT);
    assign s_accept  = s_tvalid && s_tready;
    assign idx_last  = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == CNT_W'(len_reg);

    smd_payload_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg     <= SYNC_RESET;
            phase_reg    <= PH_HUNT;
            addr_reg     <= '0;
            cmd_reg      <= '0;
            len_reg      <= '0;
            fill_reg     <= '0;
            em_reg       <= EM_ACCEPT;
            rd_idx_reg   <= '0;
            zero_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                sync_reg <= cfg_data;
            end
            phase_reg    <= phase_next;
            addr_reg     <= addr_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            fill_reg     <= fill_next;
            em_reg       <= em_next;
            rd_idx_reg   <= rd_idx_next;
            zero_reg     <= zero_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_comb begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        em_next     = em_reg;
        rd_idx_next = rd_idx_reg;
        zero_next   = zero_reg;
        out_next    = out_reg;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (em_reg)
            EM_ACCEPT: begin
                if (s_accept) begin
                    if (s_tuser[0]) begin
                        phase_next = PH_HUNT;
                    end else begin
                        case (phase_reg)
                            PH_SYNC: begin
                                addr_next  = s_tdata;
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR: begin
                                if ({1'b0, s_tdata} <= MAX_LEN) begin
                                    len_next   = LEN_W'(s_tdata);
                                    fill_next  = '0;
                                    phase_next = PH_LEN;
                                end else begin
                                    phase_next = PH_HUNT;
                                end
                            end
                            PH_LEN: begin
                                cmd_next   = s_tdata;
                                phase_next = PH_CMD;
                            end
                            PH_CMD: begin
                                if (fill_reg < len_reg) begin
                                    ram_we    = 1'b1;
                                    fill_next = fill_reg + LEN_W'(1);
                                end else begin
                                    phase_next  = PH_HUNT;
                                    rd_idx_next = '0;
                                    zero_next   = (len_reg == '0);
                                    em_next     = (len_reg == '0) ? EM_LOAD : EM_READ;
                                end
                            end
                            default: begin
                                phase_next = (s_tdata == sync_reg) ? PH_SYNC : PH_HUNT;
                            end
                        endcase
                    end
                end
            end
            EM_READ: begin
                ram_re  = 1'b1;
                em_next = EM_LOAD;
            end
            EM_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load             = 1'b1;
                    out_next.msg_address = addr_reg;
                    out_next.msg_command = cmd_reg;
                    out_next.msg_length  = 6'(len_reg);
                    out_next.byte_index  = 5'(rd_idx_reg);
                    out_next.payload_byte = zero_reg ? 8'h00 : ram_rd_data;
                    out_next.has_payload = !zero_reg;
                    out_next.last        = zero_reg || idx_last;
                    if (zero_reg || idx_last) begin
                        em_next = EM_ACCEPT;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        em_next     = EM_READ;
                    end
                end
            end
            default: begin
                em_next = EM_ACCEPT;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.payload_byte, out_reg.byte_index, out_reg.msg_length,
                       out_reg.msg_command, out_reg.msg_address};
    assign m_tuser  = out_reg.has_payload;
    assign m_tlast  = out_reg.last;

    `SMD_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= len_reg)
    `SMD_ASSERT_NEXT(a_start_read, s_accept && !s_tuser[0] && phase_reg == PH_CMD && fill_reg == len_reg && len_reg != '0, em_reg == EM_READ && rd_idx_reg == '0)
    `SMD_ASSERT_NEXT(a_last_done, out_load && out_next.last, em_reg == EM_ACCEPT && m_tvalid)

endmodule
